[hw/rtl/phsc_pkg.sv]
// Shared types and constants of the pH sensor conditioner.
package phsc_pkg;

  localparam int WIN_SIZE  = 10;
  localparam int TRIM_REQ  = 2;
  localparam int TRIM_EFF  = (TRIM_REQ > (WIN_SIZE - 1) / 2) ? (WIN_SIZE - 1) / 2 : TRIM_REQ;
  localparam int AVG_CNT   = WIN_SIZE - 2 * TRIM_EFF;
  localparam int IDX_W     = $clog2(WIN_SIZE);
  localparam int ACC_W     = 12 + $clog2(WIN_SIZE + 1);

  // mean by reciprocal multiply: floor(x / AVG_CNT) = (x * MEAN_RCP) >> MEAN_SH
  localparam int MEAN_SH    = 24;
  localparam int MEAN_RCP   = ((1 << MEAN_SH) + AVG_CNT - 1) / AVG_CNT;
  localparam int MEAN_RCP_W = $clog2(MEAN_RCP + 1);

  localparam int ALPHA_Q16 = 6554;
  localparam int ALPHA_W   = 17;

  localparam int DIVD_W    = 50;
  localparam int DIVS_W    = 30;
  localparam int QUO_KEEP  = 24;
  localparam int RAW_W     = 26;

  localparam int KELVIN_25C = 29815;
  localparam int KELVIN_0C  = 27315;
  localparam int MV_SCALE   = 16000;
  localparam int PH_MAX     = 14000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DANG_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DANG_HIGH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_HIGH = 3'd7;

  typedef enum logic [2:0] {
    ST_OPTIMAL    = 3'd0,
    ST_WARN_ACID  = 3'd1,
    ST_DANG_ACID  = 3'd2,
    ST_CRIT_ACID  = 3'd3,
    ST_WARN_BASE  = 3'd4,
    ST_DANG_BASE  = 3'd5,
    ST_CRIT_BASE  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_STORE, S_SORT, S_SUM, S_MDIV, S_MUL1, S_MUL2,
    S_PDIV, S_PWAIT, S_EMA_MUL, S_EMA_ADD, S_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    logic             store;
    logic             acc_clr;
    logic             sort;
    logic             sum;
    logic [IDX_W-1:0] idx;
    logic             phase;
    logic             div_start;
    logic             mean_take;
    logic             mul1;
    logic             mul2;
    logic             raw_take;
    logic             ema_mul;
    logic             ema_add;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic win_full;
    logic div_done;
    logic div_busy;
  } stat_t;

endpackage

[hw/rtl/phsc_div.sv]
// Restoring divider, one quotient bit per cycle.
module phsc_div
  import phsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W+1:0] trial;

  always_comb begin
    shifted = {rem_r, quo_r[DIVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(DIVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (!trial[DIVS_W+1]) begin
        rem_r <= trial[DIVS_W-1:0];
        quo_r <= {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DIVS_W-1:0];
        quo_r <= {quo_r[DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/phsc_datapath.sv]
// Datapath: window, sorter, mean, slope scaling, EMA, clamp and status.
module phsc_datapath
  import phsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [11:0]           in_sample_mv,
  input  logic                  in_use_window,
  input  logic signed [14:0]    in_temp_centi_c,
  input  logic                  in_temp_valid,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [13:0]           out_ph_mph,
  output logic [15:0]           out_mean_mv_x16,
  output logic [2:0]            out_status_code,
  output logic                  out_was_clamped
);

  logic signed [17:0] slope_r;
  logic signed [18:0] icpt_r;
  logic [13:0] crit_lo_r, dang_lo_r, warn_lo_r, crit_hi_r, dang_hi_r, warn_hi_r;

  logic [11:0]        samp_r;
  logic signed [14:0] temp_r;
  logic               tvalid_r;
  logic [11:0]        win_r   [WIN_SIZE];
  logic [11:0]        win_nxt [WIN_SIZE];
  logic [IDX_W-1:0]   fill_r;
  logic [ACC_W-1:0]   acc_r;
  logic [15:0]        mv16_r;
  logic [33:0]        prod1_r;
  logic [48:0]        prod2_r;
  logic [DIVS_W-1:0]  den_r;
  logic               neg_r;
  logic signed [RAW_W-1:0] raw_r;
  logic signed [31:0] filt_r;
  logic               primed_r;
  logic [49:0]        emap_r;
  logic               eneg_r;

  logic [13:0]        ph_r;
  logic [15:0]        omv_r;
  status_t            ost_r;
  logic               ocl_r;

  logic              div_start, div_busy, div_done;
  logic [DIVD_W-1:0] div_dvd, div_quo;
  logic [DIVS_W-1:0] div_dsr;

  phsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign div_start = cmd.div_start;

  always_comb begin
    div_dvd = {1'b0, prod2_r} + DIVD_W'(den_r >> 1);
    div_dsr = den_r;
  end

  // window write and odd/even transposition pass
  always_comb begin
    for (int i = 0; i < WIN_SIZE; i++) win_nxt[i] = win_r[i];
    if (cmd.sort) begin
      for (int i = 0; i < WIN_SIZE - 1; i++) begin
        if ((i % 2) == int'(cmd.phase) && win_r[i] > win_r[i+1]) begin
          win_nxt[i]   = win_r[i+1];
          win_nxt[i+1] = win_r[i];
        end
      end
    end else if (cmd.store) begin
      win_nxt[fill_r] = samp_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_SIZE; i++) win_r[i] <= win_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.store) begin
      fill_r <= (fill_r == IDX_W'(WIN_SIZE - 1)) ? '0 : fill_r + 1'b1;
    end
  end

  // arithmetic helpers
  logic [18:0]        slope_ext;
  logic [17:0]        slope_mag;
  logic [16:0]        kel;
  logic [RAW_W-1:0]   qmag;
  logic signed [33:0] ediff;
  logic [32:0]        emag;
  logic [33:0]        estep;
  logic signed [34:0] filt_sum;
  logic [ACC_W+3:0]   mean_x;
  logic [ACC_W+MEAN_RCP_W+3:0] mean_p;

  always_comb begin
    slope_ext = slope_r[17] ? 19'(-{slope_r[17], slope_r}) : 19'({slope_r[17], slope_r});
    slope_mag = slope_ext[17:0];
    kel       = 17'(temp_r) + 17'(KELVIN_0C);
    qmag      = RAW_W'(div_quo[QUO_KEEP-1:0]);
    ediff     = 34'(raw_r) - 34'(filt_r);
    emag      = ediff[33] ? 33'(-ediff) : 33'(ediff);
    estep     = 34'((emap_r + 50'd32768) >> 16);
    filt_sum  = eneg_r ? (35'(filt_r) - 35'(estep)) : (35'(filt_r) + 35'(estep));
    mean_x    = {acc_r, 4'b0000} + (ACC_W+4)'(AVG_CNT / 2);
    mean_p    = mean_x * MEAN_RCP_W'(MEAN_RCP);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r   <= in_sample_mv;
      temp_r   <= in_temp_centi_c;
      tvalid_r <= in_temp_valid;
      if (!in_use_window) mv16_r <= {in_sample_mv, 4'b0000};
    end
    if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.sum) acc_r <= acc_r + ACC_W'(win_r[cmd.idx]);
    if (cmd.mean_take) mv16_r <= mean_p[MEAN_SH+15:MEAN_SH];
    if (cmd.mul1) begin
      prod1_r <= 34'(slope_mag * mv16_r);
      neg_r   <= slope_r[17];
      den_r   <= tvalid_r ? DIVS_W'(kel[15:0] * 14'(MV_SCALE)) : DIVS_W'(MV_SCALE);
    end
    if (cmd.mul2) begin
      prod2_r <= tvalid_r ? 49'(prod1_r * 15'(KELVIN_25C)) : 49'(prod1_r);
    end
    if (cmd.raw_take) begin
      raw_r <= (neg_r ? -$signed(qmag) : $signed(qmag)) + RAW_W'(icpt_r);
    end
    if (cmd.ema_mul) begin
      emap_r <= 50'(emag * ALPHA_W'(ALPHA_Q16));
      eneg_r <= ediff[33];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= '0;
      primed_r <= 1'b0;
    end else if (cfg_wr && (cfg_index == REG_SLOPE || cfg_index == REG_INTERCEPT)) begin
      primed_r <= 1'b0;
    end else if (cmd.ema_add) begin
      primed_r <= 1'b1;
      filt_r   <= primed_r ? filt_sum[31:0] : 32'(raw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r   <= -18'sd5700;
      icpt_r    <= 19'sd21250;
      crit_lo_r <= 14'd5000;
      dang_lo_r <= 14'd6000;
      warn_lo_r <= 14'd6500;
      crit_hi_r <= 14'd9500;
      dang_hi_r <= 14'd8500;
      warn_hi_r <= 14'd8500;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SLOPE:     slope_r   <= cfg_data[17:0];
        REG_INTERCEPT: icpt_r    <= cfg_data;
        REG_CRIT_LOW:  crit_lo_r <= cfg_data[13:0];
        REG_DANG_LOW:  dang_lo_r <= cfg_data[13:0];
        REG_WARN_LOW:  warn_lo_r <= cfg_data[13:0];
        REG_CRIT_HIGH: crit_hi_r <= cfg_data[13:0];
        REG_DANG_HIGH: dang_hi_r <= cfg_data[13:0];
        REG_WARN_HIGH: warn_hi_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // clamp and grade
  logic [13:0] ph_c;
  logic        cl_c;
  status_t     st_c;

  always_comb begin
    if (filt_r < 0) begin
      ph_c = '0;
      cl_c = 1'b1;
    end else if (filt_r > 32'sd14000) begin
      ph_c = 14'(PH_MAX);
      cl_c = 1'b1;
    end else begin
      ph_c = filt_r[13:0];
      cl_c = 1'b0;
    end
    if (ph_c <= crit_lo_r)      st_c = ST_CRIT_ACID;
    else if (ph_c <= dang_lo_r) st_c = ST_DANG_ACID;
    else if (ph_c < warn_lo_r)  st_c = ST_WARN_ACID;
    else if (ph_c >= crit_hi_r) st_c = ST_CRIT_BASE;
    else if (ph_c > dang_hi_r)  st_c = ST_DANG_BASE;
    else if (ph_c > warn_hi_r)  st_c = ST_WARN_BASE;
    else                        st_c = ST_OPTIMAL;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ph_r  <= ph_c;
      omv_r <= mv16_r;
      ost_r <= st_c;
      ocl_r <= cl_c;
    end
  end

  assign out_ph_mph      = ph_r;
  assign out_mean_mv_x16 = omv_r;
  assign out_status_code = ost_r;
  assign out_was_clamped = ocl_r;

  assign stat.win_full = (fill_r == IDX_W'(WIN_SIZE - 1));
  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;

endmodule

[hw/rtl/phsc_ctrl.sv]
// Controller: sequences one item through the datapath.
module phsc_ctrl
  import phsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_use_window,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic             out_valid_r;
  logic             slot_free;
  logic             accept;

  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = in_use_window ? S_STORE : S_MUL1;
      S_STORE: begin
        step_nxt  = '0;
        state_nxt = stat.win_full ? S_SORT : S_IDLE;
      end
      S_SORT: begin
        if (step_r == IDX_W'(WIN_SIZE - 1)) begin
          step_nxt  = IDX_W'(TRIM_EFF);
          state_nxt = S_SUM;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_SUM: begin
        if (step_r == IDX_W'(TRIM_EFF + AVG_CNT - 1)) state_nxt = S_MDIV;
        else step_nxt = step_r + 1'b1;
      end
      S_MDIV:    state_nxt = S_MUL1;
      S_MUL1:    state_nxt = S_MUL2;
      S_MUL2:    state_nxt = S_PDIV;
      S_PDIV:    state_nxt = S_PWAIT;
      S_PWAIT:   if (stat.div_done) state_nxt = S_EMA_MUL;
      S_EMA_MUL: state_nxt = S_EMA_ADD;
      S_EMA_ADD: state_nxt = S_DONE;
      S_DONE:    if (slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.load         = accept;
    cmd.idx          = step_r;
    cmd.phase        = step_r[0];
    case (state_r)
      S_STORE: begin
        cmd.store   = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_SORT:    cmd.sort      = 1'b1;
      S_SUM:     cmd.sum       = 1'b1;
      S_MDIV:    cmd.mean_take = 1'b1;
      S_MUL1:    cmd.mul1      = 1'b1;
      S_MUL2:    cmd.mul2      = 1'b1;
      S_PDIV:    cmd.div_start = 1'b1;
      S_PWAIT:   cmd.raw_take  = stat.div_done;
      S_EMA_MUL: cmd.ema_mul   = 1'b1;
      S_EMA_ADD: cmd.ema_add   = 1'b1;
      S_DONE:    cmd.out_load  = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cmd.out_load)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");
  a_window_store: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_use_window) |=> state_r == S_STORE)
    else $error("window transfer did not store");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left result pending");
`endif

endmodule

[hw/rtl/ph_sensor_conditioner.sv]
// Top level: pH sensor conditioner, trimmed-mean window, slope scaling, EMA.
// A window item that only stores its sample passes through S_STORE and back to idle.
// Items that produce a result pass the slope multiplies, the bit-serial divider
// for the kelvin division and the EMA; a full window first adds 10 sort passes
// and 6 sum steps. The mean uses a reciprocal multiply.
// Synchronous active-low reset restores register defaults, empties the window
// and unprimes the filter; no clearing pass is needed.
module ph_sensor_conditioner
  import phsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [11:0]           in_sample_mv,
  input  logic                  in_use_window,
  input  logic signed [14:0]    in_temp_centi_c,
  input  logic                  in_temp_valid,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [13:0]           out_ph_mph,
  output logic [15:0]           out_mean_mv_x16,
  output logic [2:0]            out_status_code,
  output logic                  out_was_clamped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  phsc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_use_window (in_use_window),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  phsc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_sample_mv    (in_sample_mv),
    .in_use_window   (in_use_window),
    .in_temp_centi_c (in_temp_centi_c),
    .in_temp_valid   (in_temp_valid),
    .cfg_wr          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ph_mph      (out_ph_mph),
    .out_mean_mv_x16 (out_mean_mv_x16),
    .out_status_code (out_status_code),
    .out_was_clamped (out_was_clamped)
  );

endmodule

[verif/phsc_checker.sv]
// Checker for the pH sensor conditioner: predicts each reading and compares the result channel.
`timescale 1ns / 1ps
module phsc_checker
  import phsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [11:0]           in_sample_mv,
  input  logic                  in_use_window,
  input  logic signed [14:0]    in_temp_centi_c,
  input  logic                  in_temp_valid,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [13:0]           out_ph_mph,
  input  logic [15:0]           out_mean_mv_x16,
  input  logic [2:0]            out_status_code,
  input  logic                  out_was_clamped,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  typedef struct {
    logic [13:0] ph;
    logic [15:0] mv16;
    status_t     status;
    logic        clamped;
  } reading_t;

  reading_t    readings_q[$];

  longint      slope_mph;
  longint      icpt_mph;
  int          crit_lo, dang_lo, warn_lo, crit_hi, dang_hi, warn_hi;
  logic [11:0] win_buf [WIN_SIZE];
  int          win_fill;
  int          ema_mph;
  bit          ema_primed;

  // nearest, ties away from zero; den > 0
  function automatic longint div_nearest(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic logic [15:0] trimmed_mean_x16();
    int     srt [WIN_SIZE];
    int     i, j, v;
    longint sum;
    sum = 0;
    for (i = 0; i < WIN_SIZE; i++) begin
      v = win_buf[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    for (i = TRIM_EFF; i < TRIM_EFF + AVG_CNT; i++) sum += srt[i];
    return 16'((sum * 16 + AVG_CNT / 2) / AVG_CNT);
  endfunction

  task automatic predict_reading(input logic [11:0] mv, input logic win,
                                 input logic signed [14:0] temp, input logic tval);
    reading_t r;
    longint   num, den, raw, ph;
    r.clamped = 1'b0;
    if (win) begin
      if (win_fill >= WIN_SIZE) win_fill = 0;
      win_buf[win_fill] = mv;
      win_fill++;
      if (win_fill < WIN_SIZE) return;
      win_fill = 0;
      r.mv16 = trimmed_mean_x16();
    end else begin
      r.mv16 = {mv, 4'd0};
    end
    num = slope_mph * longint'(r.mv16);
    den = MV_SCALE;
    if (tval) begin
      num *= KELVIN_25C;
      den *= longint'(temp) + KELVIN_0C;
    end
    raw = div_nearest(num, den) + icpt_mph;
    if (!ema_primed) begin
      ema_mph = int'(raw);
      ema_primed = 1'b1;
    end else begin
      ema_mph = int'(longint'(ema_mph) +
                     div_nearest(longint'(ALPHA_Q16) * (raw - ema_mph), 65536));
    end
    ph = ema_mph;
    if (ph < 0) begin ph = 0; r.clamped = 1'b1; end
    if (ph > PH_MAX) begin ph = PH_MAX; r.clamped = 1'b1; end
    if (ph <= crit_lo)      r.status = ST_CRIT_ACID;
    else if (ph <= dang_lo) r.status = ST_DANG_ACID;
    else if (ph < warn_lo)  r.status = ST_WARN_ACID;
    else if (ph >= crit_hi) r.status = ST_CRIT_BASE;
    else if (ph > dang_hi)  r.status = ST_DANG_BASE;
    else if (ph > warn_hi)  r.status = ST_WARN_BASE;
    else                    r.status = ST_OPTIMAL;
    r.ph = 14'(ph);
    readings_q.push_back(r);
  endtask

  always @(posedge clk) begin
    reading_t e;
    if (!rst_n) begin
      slope_mph  = -5700;
      icpt_mph   = 21250;
      crit_lo    = 5000;
      dang_lo    = 6000;
      warn_lo    = 6500;
      crit_hi    = 9500;
      dang_hi    = 8500;
      warn_hi    = 8500;
      win_fill   = 0;
      ema_mph    = 0;
      ema_primed = 1'b0;
      readings_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (readings_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result ph=%0d mv16=%0d st=%0d cl=%0b", $realtime,
                     out_ph_mph, out_mean_mv_x16, out_status_code, out_was_clamped);
        end else begin
          e = readings_q.pop_front();
          if (out_ph_mph !== e.ph || out_mean_mv_x16 !== e.mv16 ||
              out_status_code !== e.status || out_was_clamped !== e.clamped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp ph=%0d mv16=%0d st=%0d cl=%0b, got ph=%0d mv16=%0d st=%0d cl=%0b",
                       $realtime, e.ph, e.mv16, e.status, e.clamped, out_ph_mph,
                       out_mean_mv_x16, out_status_code, out_was_clamped);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLOPE: begin
            slope_mph  = longint'($signed(cfg_data[17:0]));
            ema_primed = 1'b0;
          end
          REG_INTERCEPT: begin
            icpt_mph   = longint'($signed(cfg_data[18:0]));
            ema_primed = 1'b0;
          end
          REG_CRIT_LOW:  crit_lo = cfg_data[13:0];
          REG_DANG_LOW:  dang_lo = cfg_data[13:0];
          REG_WARN_LOW:  warn_lo = cfg_data[13:0];
          REG_CRIT_HIGH: crit_hi = cfg_data[13:0];
          REG_DANG_HIGH: dang_hi = cfg_data[13:0];
          REG_WARN_HIGH: warn_hi = cfg_data[13:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_reading(in_sample_mv, in_use_window, in_temp_centi_c, in_temp_valid);
    end
    pending = readings_q.size();
  end

endmodule

[verif/tb_ph_sensor_conditioner.sv]
// Testbench top for the pH sensor conditioner: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_ph_sensor_conditioner;
  import phsc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 200;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [11:0]           in_sample_mv = '0;
  logic                  in_use_window = 1'b0;
  logic signed [14:0]    in_temp_centi_c = '0;
  logic                  in_temp_valid = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [13:0]           out_ph_mph;
  logic [15:0]           out_mean_mv_x16;
  logic [2:0]            out_status_code;
  logic                  out_was_clamped;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SLOPE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  always #1 clk = ~clk;

  ph_sensor_conditioner u_dut (.*);

  phsc_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_sample(input logic [11:0] mv, input logic win,
                             input logic signed [14:0] temp, input logic tval);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_mv    <= mv;
    in_use_window   <= win;
    in_temp_centi_c <= temp;
    in_temp_valid   <= tval;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // idle the input, let every reading drain, then give window-only items time to finish
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [13:0] pick_threshold();
    case ($urandom_range(0, 3))
      0:       return 14'd0;
      1:       return 14'h3FFF;
      default: return 14'($urandom_range(0, 16383));
    endcase
  endfunction

  task automatic apply_setting(input int k);
    logic [17:0] slope;
    logic [18:0] icpt;
    case (k % 4)
      0: begin slope = 18'sh1FFFF; icpt = 19'h40000; end   // most positive slope, lowest offset
      1: begin slope = 18'sh20000; icpt = 19'h3FFFF; end   // most negative slope, highest offset
      2: begin slope = -18'sd5700; icpt = 19'd21250; end
      default: begin
        slope = 18'($urandom_range(0, 262143));
        icpt  = 19'($urandom_range(0, 524287));
      end
    endcase
    // bit 18 is unused for the slope and is toggled at random
    write_reg(REG_SLOPE, {1'($urandom_range(0, 1)), slope});
    write_reg(REG_INTERCEPT, icpt);
    if (k % 3 == 2) begin
      write_reg(REG_CRIT_LOW, 19'd0);
      write_reg(REG_DANG_LOW, 19'd0);
      write_reg(REG_WARN_LOW, 19'd0);
      write_reg(REG_CRIT_HIGH, 19'h3FFF);
      write_reg(REG_DANG_HIGH, 19'h3FFF);
      write_reg(REG_WARN_HIGH, 19'h3FFF);
    end else begin
      write_reg(REG_CRIT_LOW,  {5'($urandom_range(0, 31)), pick_threshold()});
      write_reg(REG_DANG_LOW,  {5'($urandom_range(0, 31)), pick_threshold()});
      write_reg(REG_WARN_LOW,  {5'($urandom_range(0, 31)), pick_threshold()});
      write_reg(REG_CRIT_HIGH, {5'($urandom_range(0, 31)), pick_threshold()});
      write_reg(REG_DANG_HIGH, {5'($urandom_range(0, 31)), pick_threshold()});
      write_reg(REG_WARN_HIGH, {5'($urandom_range(0, 31)), pick_threshold()});
    end
  endtask

  function automatic logic signed [14:0] pick_temp();
    case ($urandom_range(0, 5))
      0:       return 15'sh4000;
      1:       return 15'sd16383;
      2:       return 15'($urandom_range(0, 32767));
      default: return 15'(int'($urandom_range(0, 17500)) - 5000);
    endcase
  endfunction

  function automatic logic [11:0] pick_mv();
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return 12'hFFF;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic random_items(input int n);
    int b, j;
    logic signed [14:0] t;
    logic tv;
    b = 0;
    while (b < n) begin
      if ($urandom_range(0, 3) != 0) begin
        // full window, mostly at one temperature with some samples at a stray one; else a single item
        t  = pick_temp();
        tv = 1'($urandom_range(0, 1));
        for (j = 0; j < WIN_SIZE; j++)
          send_sample(pick_mv(), 1'b1, ($urandom_range(0, 4) == 0) ? pick_temp() : t, tv);
        b += WIN_SIZE;
      end else begin
        send_sample(pick_mv(), $urandom_range(0, 5) == 0, pick_temp(),
                    1'($urandom_range(0, 1)));
        b++;
      end
    end
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes in direct mode, then one window with outliers
    send_sample(12'd0, 1'b0, 15'sd0, 1'b0);
    send_sample(12'hFFF, 1'b0, 15'sd2500, 1'b1);
    send_sample(12'd0, 1'b0, 15'sh4000, 1'b1);
    send_sample(12'hFFF, 1'b0, 15'sh4000, 1'b1);
    send_sample(12'hFFF, 1'b0, 15'sd16383, 1'b1);
    send_sample(12'd1000, 1'b0, -15'sd5000, 1'b1);
    send_sample(12'd3000, 1'b0, 15'sd12500, 1'b0);
    send_sample(12'd1, 1'b1, 15'sd2500, 1'b1);
    send_sample(12'hFFF, 1'b1, 15'sd2500, 1'b1);
    // direct item in the middle of a window leaves the fill alone
    send_sample(12'd2000, 1'b0, 15'sd2500, 1'b0);
    send_sample(12'd0, 1'b1, 15'sd2500, 1'b1);
    send_sample(12'hFFE, 1'b1, 15'sd2500, 1'b1);
    send_sample(12'd1500, 1'b1, 15'sd2500, 1'b1);
    send_sample(12'd1501, 1'b1, 15'sd2500, 1'b1);
    send_sample(12'd1499, 1'b1, 15'sd2500, 1'b1);
    send_sample(12'd1500, 1'b1, 15'sd2500, 1'b1);
    send_sample(12'd1502, 1'b1, 15'sd2500, 1'b1);
    send_sample(12'd1498, 1'b1, 15'sd2500, 1'b1);
    drain_block();

    // slope and offset that drive the filter below 0 and above 14 pH
    write_reg(REG_SLOPE, 19'(-18'sd100000));
    write_reg(REG_INTERCEPT, 19'd0);
    send_sample(12'hFFF, 1'b0, 15'sd0, 1'b0);
    send_sample(12'hFFF, 1'b0, 15'sd0, 1'b0);
    drain_block();
    write_reg(REG_SLOPE, 19'd100000);
    send_sample(12'hFFF, 1'b0, 15'sd0, 1'b0);
    send_sample(12'd0, 1'b0, 15'sd0, 1'b0);
    drain_block();

    for (k = 0; k < 6; k++) begin
      apply_setting(k);
      if (k == 2) hold_req = 1'b1;
      if (k == 5) no_idle = 1'b1;
      random_items(250);
      drain_block();
    end

    if (mismatches == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/phsc_pkg.sv
hw/rtl/phsc_div.sv
hw/rtl/phsc_datapath.sv
hw/rtl/phsc_ctrl.sv
hw/rtl/ph_sensor_conditioner.sv
verif/phsc_checker.sv
verif/tb_ph_sensor_conditioner.sv
